>>> src/postfix_stack_evaluator_core_defines.svh
// Assertion macros for the postfix stack evaluator checker.
// Depends on signals named clock and reset in the asserting scope.
`ifndef POSTFIX_STACK_EVALUATOR_CORE_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_CORE_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define PSE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pse check failed");

// Consequent must hold in the same cycle as the antecedent.
`define PSE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pse check failed");

`endif

>>> src/pse_pkg.sv
// Shared types and constants of the postfix stack evaluator.
// No dependencies; used by the core, the arithmetic unit and the checker.
package pse_pkg;

   localparam int WORD_W      = 32;
   localparam int SYM_W       = 8;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 40;

   localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;
   localparam logic [SYM_W-1:0] SYM_NINE  = 8'h39;
   localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
   localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
   localparam logic [SYM_W-1:0] SYM_STAR  = 8'h2A;
   localparam logic [SYM_W-1:0] SYM_SLASH = 8'h2F;

   localparam logic [WORD_W-1:0] NEG_ONE = '1;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DIVZERO  = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ALU_ADD = 2'd0,
      ALU_SUB = 2'd1,
      ALU_MUL = 2'd2,
      ALU_DIV = 2'd3
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;

endpackage

>>> src/pse_stack.sv
// Operand stack memory: one write port, one read port with registered data.
// Depends on pse_pkg for the word width.
module pse_stack
   import pse_pkg::*;
#(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   // write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/pse_alu.sv
// Shared arithmetic unit: add, subtract and multiply straight to the result
// register, signed divide as a radix-2 restoring iteration. Depends on pse_pkg.
module pse_alu
   import pse_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  alu_req_type       alu_req,
   input  logic [WORD_W-1:0] lhs,
   input  logic [WORD_W-1:0] rhs,
   output logic              done,
   output logic [WORD_W-1:0] result
);

   localparam int CNT_W = $clog2(WORD_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

   typedef enum logic [1:0] {A_IDLE, A_DIV, A_FIX} alu_state_type;

   alu_state_type     state_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [WORD_W-1:0] quo_ff;
   logic [WORD_W-1:0] rem_ff;
   logic [WORD_W-1:0] div_ff;
   logic              neg_ff;
   logic [WORD_W-1:0] res_ff;
   logic              done_ff;

   logic [WORD_W-1:0] lhs_mag;
   logic [WORD_W-1:0] rhs_mag;
   logic [WORD_W:0]   shifted;
   logic [WORD_W:0]   diff;

   // operand magnitudes; the most negative value maps onto itself unsigned
   assign lhs_mag = lhs[WORD_W-1] ? (~lhs + 1'b1) : lhs;
   assign rhs_mag = rhs[WORD_W-1] ? (~rhs + 1'b1) : rhs;

   // one quotient bit per cycle
   assign shifted = {rem_ff, quo_ff[WORD_W-1]};
   assign diff    = shifted - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            A_IDLE: begin
               if (alu_req.start) begin
                  unique case (alu_req.op)
                     ALU_ADD: begin
                        res_ff  <= lhs + rhs;
                        done_ff <= 1'b1;
                     end
                     ALU_SUB: begin
                        res_ff  <= lhs - rhs;
                        done_ff <= 1'b1;
                     end
                     ALU_MUL: begin
                        res_ff  <= lhs * rhs;
                        done_ff <= 1'b1;
                     end
                     ALU_DIV: begin
                        quo_ff   <= lhs_mag;
                        div_ff   <= rhs_mag;
                        rem_ff   <= '0;
                        neg_ff   <= lhs[WORD_W-1] ^ rhs[WORD_W-1];
                        cnt_ff   <= '0;
                        state_ff <= A_DIV;
                     end
                  endcase
               end
            end
            A_DIV: begin
               if (!diff[WORD_W]) begin
                  rem_ff <= diff[WORD_W-1:0];
                  quo_ff <= {quo_ff[WORD_W-2:0], 1'b1};
               end else begin
                  rem_ff <= shifted[WORD_W-1:0];
                  quo_ff <= {quo_ff[WORD_W-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_LAST) begin
                  state_ff <= A_FIX;
               end
            end
            A_FIX: begin
               // apply the sign; truncation toward zero falls out of magnitudes
               res_ff   <= neg_ff ? (~quo_ff + 1'b1) : quo_ff;
               done_ff  <= 1'b1;
               state_ff <= A_IDLE;
            end
            default: begin
               state_ff <= A_IDLE;
            end
         endcase
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

>>> src/postfix_stack_evaluator_core.sv
// Postfix expression evaluator: one character per input word, one result
// word per expression. Uses pse_pkg, pse_stack and pse_alu.
//
// Usage:
//   req channel: req_tdata[7:0] carries the ASCII character, req_tlast marks
//   the final character of an expression. A digit pushes 0..9; + - * / pop
//   two operands and push the 32-bit result; any other character pops two
//   operands and drops them.
//   rsp channel: one word per expression, issued after the final character:
//   rsp_tdata[31:0] value, rsp_tdata[33:32] status (ok, divide by zero,
//   overflow, empty pop). The stack and the error clear after each result.
// Timing: one character at a time; req_tready is high only between items.
//   A digit is decoded and pushed; + - * / pop two operands and use the
//   shared arithmetic unit, where / runs 32 quotient steps, setup and sign fix.
//   The final character then loads the result register, reading back the top if any.
// Reset: synchronous, active high; empties the stack, clears the error and
//   drops any pending result. Stack memory contents are not cleared.
// Stall: a result waits in the output register while rsp_tready is low; the
//   next expression is still taken in, and only its own result waits.
module postfix_stack_evaluator_core
   import pse_pkg::*;
#(
   parameter int STACK_DEPTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [7:0] symbol
   input  logic                   req_tlast,   // last_symbol
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // [31:0] value, [33:32] status
);

   localparam int PTR_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_FULL = PTR_W'(STACK_DEPTH);
   localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_POP_RHS, S_POP_LHS, S_OPER,
      S_WAIT_ALU, S_FINISH, S_FINAL_RD, S_EMIT
   } state_type;

   state_type         state_ff;
   logic [SYM_W-1:0]  sym_ff;
   logic              last_ff;
   logic [PTR_W-1:0]  sp_ff;
   status_type        err_ff;
   logic [WORD_W-1:0] rhs_ff;
   logic              pend_ff;
   logic [WORD_W-1:0] fin_val_ff;
   status_type        fin_st_ff;
   logic              rsp_tvalid_ff;
   logic [WORD_W-1:0] rsp_value_ff;
   status_type        rsp_status_ff;

   logic [PTR_W-1:0]  sp_dec;
   logic              stack_full;
   logic              stack_empty;
   logic              is_digit;
   logic              is_arith;
   alu_op_type        sym_op;
   logic              push_go;
   logic              emit_go;
   logic              wr_en;
   logic [WORD_W-1:0] wr_data;
   logic [WORD_W-1:0] rd_data;
   logic [WORD_W-1:0] lhs_val;
   alu_req_type       alu_req;
   logic              alu_done;
   logic [WORD_W-1:0] alu_result;

   // keep the first overflow or empty-pop code
   function automatic status_type note_err(status_type cur, status_type code);
      return (cur == ST_OK) ? code : cur;
   endfunction

   // decode the held character
   assign is_digit = (sym_ff >= SYM_ZERO) && (sym_ff <= SYM_NINE);
   always_comb begin
      is_arith = 1'b1;
      sym_op   = ALU_ADD;
      unique case (sym_ff)
         SYM_PLUS:  sym_op = ALU_ADD;
         SYM_MINUS: sym_op = ALU_SUB;
         SYM_STAR:  sym_op = ALU_MUL;
         SYM_SLASH: sym_op = ALU_DIV;
         default:   is_arith = 1'b0;
      endcase
   end

   assign sp_dec      = sp_ff - PTR_ONE;
   assign stack_full  = (sp_ff == PTR_FULL);
   assign stack_empty = (sp_ff == '0);

   // push a digit or an arithmetic result
   assign push_go = ((state_ff == S_DECODE) && (err_ff != ST_DIVZERO) && is_digit) ||
                    ((state_ff == S_WAIT_ALU) && alu_done);
   assign wr_en   = push_go && !stack_full;
   assign wr_data = (state_ff == S_DECODE)
                    ? {{(WORD_W-SYM_W){1'b0}}, sym_ff - SYM_ZERO}
                    : alu_result;

   // load the output register once it is free
   assign emit_go = (state_ff == S_EMIT) && (!rsp_tvalid_ff || rsp_tready);

   // left operand arrives from memory unless the pop found the stack empty
   assign lhs_val = pend_ff ? rd_data : NEG_ONE;

   // start the shared unit; a zero divisor never reaches it
   assign alu_req.start = (state_ff == S_OPER) && is_arith &&
                          !((sym_op == ALU_DIV) && (rhs_ff == '0));
   assign alu_req.op    = sym_op;

   pse_stack #(
      .DEPTH  (STACK_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (sp_ff[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (sp_dec[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   pse_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .lhs     (lhs_val),
      .rhs     (rhs_ff),
      .done    (alu_done),
      .result  (alu_result)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         sp_ff         <= '0;
         err_ff        <= ST_OK;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (emit_go) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  sym_ff   <= req_tdata[SYM_W-1:0];
                  last_ff  <= req_tlast;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               if (err_ff == ST_DIVZERO) begin
                  state_ff <= S_FINISH;
               end else if (is_digit) begin
                  if (stack_full) begin
                     err_ff <= note_err(err_ff, ST_OVERFLOW);
                  end else begin
                     sp_ff <= sp_ff + PTR_ONE;
                  end
                  state_ff <= S_FINISH;
               end else begin
                  state_ff <= S_POP_RHS;
               end
            end
            S_POP_RHS: begin
               if (stack_empty) begin
                  rhs_ff  <= NEG_ONE;
                  err_ff  <= note_err(err_ff, ST_EMPTY);
                  pend_ff <= 1'b0;
               end else begin
                  sp_ff   <= sp_dec;
                  pend_ff <= 1'b1;
               end
               state_ff <= S_POP_LHS;
            end
            S_POP_LHS: begin
               if (pend_ff) begin
                  rhs_ff <= rd_data;
               end
               if (stack_empty) begin
                  err_ff  <= note_err(err_ff, ST_EMPTY);
                  pend_ff <= 1'b0;
               end else begin
                  sp_ff   <= sp_dec;
                  pend_ff <= 1'b1;
               end
               state_ff <= S_OPER;
            end
            S_OPER: begin
               if (alu_req.start) begin
                  state_ff <= S_WAIT_ALU;
               end else begin
                  if (is_arith && (sym_op == ALU_DIV)) begin
                     err_ff <= ST_DIVZERO;
                  end
                  state_ff <= S_FINISH;
               end
            end
            S_WAIT_ALU: begin
               if (alu_done) begin
                  if (stack_full) begin
                     err_ff <= note_err(err_ff, ST_OVERFLOW);
                  end else begin
                     sp_ff <= sp_ff + PTR_ONE;
                  end
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (!last_ff) begin
                  state_ff <= S_IDLE;
               end else if (err_ff == ST_DIVZERO) begin
                  fin_val_ff <= NEG_ONE;
                  fin_st_ff  <= err_ff;
                  state_ff   <= S_EMIT;
               end else if (stack_empty) begin
                  fin_val_ff <= NEG_ONE;
                  fin_st_ff  <= note_err(err_ff, ST_EMPTY);
                  state_ff   <= S_EMIT;
               end else begin
                  state_ff <= S_FINAL_RD;
               end
            end
            S_FINAL_RD: begin
               fin_val_ff <= rd_data;
               fin_st_ff  <= err_ff;
               state_ff   <= S_EMIT;
            end
            S_EMIT: begin
               // hold until the output register is free
               if (emit_go) begin
                  rsp_value_ff  <= fin_val_ff;
                  rsp_status_ff <= fin_st_ff;
                  sp_ff         <= '0;
                  err_ff        <= ST_OK;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-WORD_W-2){1'b0}}, rsp_status_ff, rsp_value_ff};

endmodule

>>> src/pse_checker.sv
// Port-level checks of the postfix stack evaluator, bound to the top level.
// Depends on pse_pkg and the assertion macros header.
`include "postfix_stack_evaluator_core_defines.svh"

module pse_checker
   import pse_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [WORD_W-1:0] rsp_value;
   logic              rsp_divzero;

   // split the result word
   assign rsp_value   = rsp_tdata[WORD_W-1:0];
   assign rsp_divzero = rsp_tvalid && (rsp_tdata[WORD_W+1:WORD_W] == ST_DIVZERO);

   // a taken character leaves the block busy in the following cycle
   `PSE_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)

   // divide by zero always reports minus one
   `PSE_ASSERT_NOW(a_divzero_value, rsp_divzero, rsp_value == NEG_ONE)

   // a stalled result word stays offered
   `PSE_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // leaving reset the block is empty and ready
   `PSE_ASSERT_NOW(a_reset_idle, $past(reset), req_tready && !rsp_tvalid)

endmodule

bind postfix_stack_evaluator_core pse_checker u_pse_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> dv/postfix_stack_evaluator_core_test.sv
// Self-checking testbench for postfix_stack_evaluator_core: drives expressions
// one character word at a time and checks each result word against a predictor.
// Depends on pse_pkg and the core RTL only.
`timescale 1ns / 100ps

module postfix_stack_evaluator_core_test;
   import pse_pkg::*;

   localparam int STACK_DEPTH    = 32;
   localparam int RANDOM_ITEMS   = 1100;
   localparam int DRAIN_CYCLES   = 64;
   localparam int IDLE_PERCENT   = 12;

   localparam logic [SYM_W-1:0] OPERATORS [4] = '{SYM_PLUS, SYM_MINUS, SYM_STAR, SYM_SLASH};

   typedef struct {
      logic [WORD_W-1:0] value;
      status_type        status;
   } result_word_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // [7:0] symbol
   logic                   req_tlast;   // last_symbol
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // [31:0] value, [33:32] status

   // Predictor state: operand stack, fill level and sticky error code
   logic [WORD_W-1:0] eval_stack [STACK_DEPTH];
   int unsigned       eval_depth;
   status_type        eval_error;

   result_word_type   pending_results [$];
   logic [SYM_W-1:0]  symbol_run [$];
   int unsigned       live_symbols;
   int unsigned       mismatches;
   bit                gaps_on;

   postfix_stack_evaluator_core #(
      .STACK_DEPTH(STACK_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void note_fault(input status_type code);
      if (eval_error == ST_OK) eval_error = code;
   endfunction

   function automatic void push_operand(input logic [WORD_W-1:0] operand);
      if (eval_depth >= STACK_DEPTH) begin
         note_fault(ST_OVERFLOW);
      end else begin
         eval_stack[eval_depth] = operand;
         eval_depth++;
      end
   endfunction

   function automatic logic [WORD_W-1:0] pop_operand();
      if (eval_depth == 0) begin
         note_fault(ST_EMPTY);
         return NEG_ONE;
      end
      eval_depth--;
      return eval_stack[eval_depth];
   endfunction

   // Apply one accepted character; queue the result word on the final one
   function automatic void evaluate_symbol(input logic [SYM_W-1:0] symbol, input logic last);
      logic [WORD_W-1:0] rhs;
      logic [WORD_W-1:0] lhs;
      longint            quotient;
      result_word_type   result;
      live_symbols++;
      if (eval_error != ST_DIVZERO) begin
         if (symbol >= SYM_ZERO && symbol <= SYM_NINE) begin
            push_operand(WORD_W'(symbol - SYM_ZERO));
         end else begin
            rhs = pop_operand();
            lhs = pop_operand();
            case (symbol)
               SYM_PLUS:  push_operand(lhs + rhs);
               SYM_MINUS: push_operand(lhs - rhs);
               SYM_STAR:  push_operand(lhs * rhs);
               SYM_SLASH: begin
                  if (rhs == '0) begin
                     eval_error = ST_DIVZERO;
                  end else begin
                     // widen so the most negative value over -1 wraps cleanly
                     quotient = longint'($signed(lhs)) / longint'($signed(rhs));
                     push_operand(quotient[WORD_W-1:0]);
                  end
               end
               default: ;
            endcase
         end
      end
      if (last) begin
         result.value  = (eval_error == ST_DIVZERO) ? NEG_ONE : pop_operand();
         result.status = eval_error;
         pending_results.push_back(result);
         eval_depth = 0;
         eval_error = ST_OK;
      end
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
                                  input logic [WORD_W-1:0] got);
      $display("ERROR at %0t: %s: expected %0d, got %0d", $time, what,
               $signed(want), $signed(got));
      mismatches++;
   endtask

   // Compare each accepted result word with the oldest expectation
   always @(posedge clock) begin : check_results
      result_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result word with none pending", '0, rsp_tdata[31:0]);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[31:0] !== want.value)
               report_mismatch("value", want.value, rsp_tdata[31:0]);
            if (rsp_tdata[33:32] !== want.status)
               report_mismatch("status", WORD_W'(want.status), WORD_W'(rsp_tdata[33:32]));
         end
      end
   end

   // Stall the result channel at random while gaps are enabled
   always @(negedge clock) begin
      rsp_tready <= !gaps_on || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // ---------------------------------------------------------------- stimulus

   // Offer one character word and hold it until accepted; call at a falling edge
   task automatic send_symbol(input logic [SYM_W-1:0] symbol, input logic last);
      while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= symbol;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      evaluate_symbol(symbol, last);
      @(negedge clock);
   endtask

   task automatic send_run();
      foreach (symbol_run[i]) send_symbol(symbol_run[i], i == symbol_run.size() - 1);
   endtask

   task automatic send_text(input string text);
      symbol_run.delete();
      for (int i = 0; i < text.len(); i++) symbol_run.push_back(text[i]);
      send_run();
   endtask

   // Build a well-formed expression with random digits and operators
   function automatic void build_expression(input int op_count, input bit pushes_first);
      int pushes_left;
      int ops_left;
      int depth;
      symbol_run.delete();
      pushes_left = op_count + 1;
      ops_left    = op_count;
      depth       = 0;
      while (pushes_left + ops_left > 0) begin
         if (ops_left > 0 && depth >= 2 &&
             (pushes_left == 0 || (!pushes_first && $urandom_range(1) == 1))) begin
            symbol_run.push_back(OPERATORS[$urandom_range(3)]);
            ops_left--;
            depth--;
         end else begin
            symbol_run.push_back(SYM_ZERO + SYM_W'($urandom_range(9)));
            pushes_left--;
            depth++;
         end
      end
   endfunction

   // Each operator once, truncating division of a negative value
   task automatic test_operators();
      send_text("9");
      send_text("83-6*9+4/");
      send_text("27-2/");
   endtask

   // Divide by zero, empty pops, error precedence, unknown characters
   task automatic test_error_cases();
      send_text("50/7+");
      send_text("+");
      send_text("+0/");
      send_text("415#");
   endtask

   // Fill the stack past its depth so the final push is dropped
   task automatic test_stack_limits();
      build_expression(STACK_DEPTH, 1'b1);
      symbol_run = symbol_run[0:STACK_DEPTH];
      send_run();
   endtask

   // Build the most negative value by wrapping, then divide it by -1
   task automatic test_division_wrap();
      symbol_run.delete();
      symbol_run.push_back("8");
      repeat (9) begin
         symbol_run.push_back("8");
         symbol_run.push_back(SYM_STAR);
      end
      symbol_run.push_back("2");
      symbol_run.push_back(SYM_STAR);
      symbol_run.push_back("0");
      symbol_run.push_back("1");
      symbol_run.push_back(SYM_MINUS);
      symbol_run.push_back(SYM_SLASH);
      send_run();
   endtask

   // Mostly well-formed expressions, some deep, some corrupted, some pure noise
   task automatic test_random_expressions();
      int unsigned start;
      int          kind;
      start = live_symbols;
      while (live_symbols - start < RANDOM_ITEMS) begin
         // hold a long stretch without any idling on either side
         gaps_on = !(live_symbols - start >= 400 && live_symbols - start < 650);
         kind = $urandom_range(99);
         if (kind < 4) begin
            build_expression($urandom_range(28, 36), 1'b1);
         end else if (kind < 74) begin
            build_expression($urandom_range(0, 8), 1'b0);
         end else if (kind < 90) begin
            build_expression($urandom_range(0, 8), 1'b0);
            foreach (symbol_run[i])
               if ($urandom_range(99) < 20) symbol_run[i] = SYM_W'($urandom_range(255));
            if ($urandom_range(3) == 0)
               symbol_run = symbol_run[0:$urandom_range(symbol_run.size() - 1)];
         end else begin
            symbol_run.delete();
            repeat ($urandom_range(1, 6)) symbol_run.push_back(SYM_W'($urandom_range(255)));
         end
         send_run();
      end
      gaps_on = 1'b1;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      gaps_on      = 1'b1;
      eval_depth   = 0;
      eval_error   = ST_OK;
      live_symbols = 0;
      mismatches   = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_operators();
      test_error_cases();
      test_stack_limits();
      test_division_wrap();
      test_random_expressions();
      req_tvalid <= 1'b0;

      // drain outstanding results, then allow for trailing words
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
